// File: rtl/vftp_pkg.sv
// shared types, codes and constants for the variable-frequency track pwm
// no dependencies
package vftp_pkg;

  // item modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_SPEED = 2'd1;
  localparam logic [1:0] MODE_POWER = 2'd2;
  localparam logic [1:0] MODE_KICK  = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_FREQ_MIN    = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_FREQ_MAX    = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_MIN_SPEED   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_MAX_SPEED   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_TWO_OUTPUTS = 3'd4;
  localparam int unsigned CFG_DW = 8;

  // configuration reset values
  localparam logic [7:0] FREQ_MIN_RST    = 8'd20;
  localparam logic [7:0] FREQ_MAX_RST    = 8'd100;
  localparam logic [6:0] MIN_SPEED_RST   = 7'd0;
  localparam logic [6:0] MAX_SPEED_RST   = 7'd100;
  localparam logic       TWO_OUTPUTS_RST = 1'b1;

  // default parameters
  localparam int unsigned DUTY_STEPS_DEF  = 100;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // arithmetic constants
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned INTERVAL_W = 14;
  localparam logic [6:0]  DUTY_MAX   = 7'd100;
  localparam logic [6:0]  DUTY_FLOOR = 7'd10;
  localparam logic [13:0] INTERVAL_NUM = 14'd10000;
  // x / 100 as (x * 5243) >> 19, exact for x below 2^15
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int unsigned SHIFT_100  = 19;
  // x / 90 as (x * 23302) >> 21, exact for x below 2^15
  localparam logic [14:0] RECIP_90   = 15'd23302;
  localparam int unsigned SHIFT_90   = 21;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        now_us;
    logic [31:0]        now_ms;
    logic signed [7:0]  speed;
    logic               power_on;
    logic [31:0]        kick_duration_ms;
  } in_beat_t;

  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic powered;
    logic kick_done;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] freq_min;
    logic [7:0] freq_max;
    logic [6:0] min_speed;
    logic [6:0] max_speed;
    logic       two_outputs;
  } cfg_t;

  // classified command between front and back
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_us;
    logic [31:0] now_ms;
    logic [7:0]  mag;
    logic        neg;
    logic        pos;
    logic        power_on;
    logic [31:0] kdur;
  } cmd_t;

endpackage

// File: rtl/vftp_front.sv
// front stage: takes input beats, splits speed into magnitude and direction
// depends on vftp_pkg
module vftp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vftp_pkg::in_beat_t in_beat,
  output logic               push,
  output vftp_pkg::cmd_t     push_cmd,
  input  logic               push_ready
);

  logic           hold_valid_r, hold_valid_nxt;
  vftp_pkg::cmd_t cmd_r, cmd_nxt;
  logic           take;

  assign in_stall = hold_valid_r && !push_ready;
  assign take     = in_valid && !in_stall;
  assign push     = hold_valid_r;
  assign push_cmd = cmd_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (push && push_ready) hold_valid_nxt = 1'b0;
    if (take) hold_valid_nxt = 1'b1;
  end

  always_comb begin
    cmd_nxt          = cmd_r;
    if (take) begin
      cmd_nxt.op       = in_beat.mode;
      cmd_nxt.now_us   = in_beat.now_us;
      cmd_nxt.now_ms   = in_beat.now_ms;
      cmd_nxt.neg      = in_beat.speed[7];
      cmd_nxt.pos      = !in_beat.speed[7] && (in_beat.speed != 8'sd0);
      // two's complement negate, -128 gives 128
      cmd_nxt.mag      = in_beat.speed[7] ? (~in_beat.speed + 8'd1) : in_beat.speed;
      cmd_nxt.power_on = in_beat.power_on;
      cmd_nxt.kdur     = in_beat.kick_duration_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

// File: rtl/vftp_queue.sv
// short command queue between front and back
// depends on vftp_pkg
module vftp_queue #(
  parameter int unsigned DEPTH = vftp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vftp_pkg::cmd_t push_cmd,
  output logic           push_ready,
  output logic           q_valid,
  output vftp_pkg::cmd_t q_cmd,
  input  logic           pop
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  vftp_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign q_valid    = (cnt_r != '0);
  assign q_cmd      = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// File: rtl/vftp_speed.sv
// speed mapping unit: duty from speed magnitude, frequency from duty,
// step interval by a bit-serial divide; depends on vftp_pkg
module vftp_speed (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [7:0]  mag,
  input  logic [6:0]  min_speed,
  input  logic [6:0]  max_speed,
  input  logic [7:0]  freq_min,
  input  logic [7:0]  freq_max,
  input  logic        ack,
  output logic        done,
  output logic [vftp_pkg::DUTY_W-1:0]     duty,
  output logic [vftp_pkg::INTERVAL_W-1:0] interval
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_MUL2 = 4'd2;
  localparam logic [3:0] S_DUTY = 4'd3;
  localparam logic [3:0] S_MUL3 = 4'd4;
  localparam logic [3:0] S_MUL4 = 4'd5;
  localparam logic [3:0] S_FREQ = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  localparam int unsigned IW = vftp_pkg::INTERVAL_W;

  logic [3:0]    st_r, st_nxt;
  logic [7:0]    mag_r, mag_nxt;
  logic [14:0]   abs_r, abs_nxt;
  logic          neg_r, neg_nxt;
  logic [8:0]    q_r, q_nxt;
  logic [6:0]    duty_r, duty_nxt;
  logic [7:0]    fq_r, fq_nxt;
  logic [IW-1:0] div_r, div_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [3:0]    cnt_r, cnt_nxt;

  logic signed [7:0]  diff1;
  logic [6:0]         absd1;
  logic signed [8:0]  diff2;
  logic [7:0]         absd2;
  logic [27:0]        prod2;
  logic [29:0]        prod4;
  logic signed [10:0] vs;
  logic signed [9:0]  fs;
  logic [8:0]         rs;
  logic               ge;
  logic [8:0]         rsub;

  assign done     = (st_r == S_DONE);
  assign duty     = duty_r;
  assign interval = div_r;

  always_comb begin
    diff1 = $signed({1'b0, max_speed}) - $signed({1'b0, min_speed});
    absd1 = diff1[7] ? 7'(-diff1) : diff1[6:0];
    diff2 = $signed({1'b0, freq_max}) - $signed({1'b0, freq_min});
    absd2 = diff2[8] ? 8'(-diff2) : diff2[7:0];
    prod2 = 28'(abs_r) * 28'(vftp_pkg::RECIP_100);
    prod4 = 30'(abs_r) * 30'(vftp_pkg::RECIP_90);
    vs    = neg_r ? ($signed({4'b0, min_speed}) - $signed({2'b0, q_r}))
                  : ($signed({4'b0, min_speed}) + $signed({2'b0, q_r}));
    fs    = neg_r ? ($signed({2'b0, freq_min}) - $signed({1'b0, q_r}))
                  : ($signed({2'b0, freq_min}) + $signed({1'b0, q_r}));
    rs    = {rem_r, div_r[IW-1]};
    ge    = (rs >= {1'b0, fq_r});
    rsub  = rs - {1'b0, fq_r};
  end

  always_comb begin
    st_nxt   = st_r;
    mag_nxt  = mag_r;
    abs_nxt  = abs_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    duty_nxt = duty_r;
    fq_nxt   = fq_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          mag_nxt = mag;
          st_nxt  = S_MUL1;
        end
      end
      S_MUL1: begin
        abs_nxt = 15'(mag_r) * 15'(absd1);
        neg_nxt = diff1[7];
        st_nxt  = S_MUL2;
      end
      S_MUL2: begin
        q_nxt  = prod2[vftp_pkg::SHIFT_100 +: 9];
        st_nxt = S_DUTY;
      end
      S_DUTY: begin
        // zero speed keeps duty zero, otherwise clamp to 0..100
        if (mag_r == 8'd0 || vs < 0) duty_nxt = '0;
        else if (vs > 11'sd100)      duty_nxt = vftp_pkg::DUTY_MAX;
        else                         duty_nxt = vs[6:0];
        st_nxt = S_MUL3;
      end
      S_MUL3: begin
        // duty at or below the floor runs at freq_min
        abs_nxt = (duty_r > vftp_pkg::DUTY_FLOOR) ?
                  15'(duty_r - vftp_pkg::DUTY_FLOOR) * 15'(absd2) : '0;
        neg_nxt = diff2[8];
        st_nxt  = S_MUL4;
      end
      S_MUL4: begin
        q_nxt  = prod4[vftp_pkg::SHIFT_90 +: 9];
        st_nxt = S_FREQ;
      end
      S_FREQ: begin
        fq_nxt  = (fs < 10'sd1) ? 8'd1 : fs[7:0];
        div_nxt = vftp_pkg::INTERVAL_NUM;
        rem_nxt = '0;
        cnt_nxt = '0;
        st_nxt  = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? rsub[7:0] : rs[7:0];
        div_nxt = {div_r[IW-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'(IW - 1)) st_nxt = S_DONE;
      end
      S_DONE: begin
        if (ack) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    mag_r  <= mag_nxt;
    abs_r  <= abs_nxt;
    neg_r  <= neg_nxt;
    q_r    <= q_nxt;
    duty_r <= duty_nxt;
    fq_r   <= fq_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

// File: rtl/vftp_back.sv
// back end: pwm step counter, power and kick-start handling, result register
// depends on vftp_pkg and vftp_speed
module vftp_back #(
  parameter int unsigned DUTY_STEPS = vftp_pkg::DUTY_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vftp_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  vftp_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output vftp_pkg::out_beat_t out_beat
);

  localparam int unsigned SW = $clog2(DUTY_STEPS + 1);
  localparam int unsigned CW = (SW > vftp_pkg::DUTY_W) ? SW : vftp_pkg::DUTY_W;
  localparam int unsigned IW = vftp_pkg::INTERVAL_W;

  localparam logic B_IDLE = 1'b0;
  localparam logic B_SPD  = 1'b1;

  logic          bst_r, bst_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [6:0]    duty_now_r, duty_now_nxt;
  logic [6:0]    duty_pend_r, duty_pend_nxt;
  logic [IW-1:0] int_now_r, int_now_nxt;
  logic [IW-1:0] int_pend_r, int_pend_nxt;
  logic [31:0]   last_us_r, last_us_nxt;
  logic          rev_r, rev_nxt;
  logic          on_r, on_nxt;
  logic [1:0]    lvl_r, lvl_nxt;
  logic [31:0]   ks_r, ks_nxt;
  logic          spd_neg_r, spd_neg_nxt;
  logic          spd_pos_r, spd_pos_nxt;
  logic          out_valid_r, out_valid_nxt;
  vftp_pkg::out_beat_t out_beat_r, out_beat_nxt;

  logic          out_free, do_simple, spd_start, spd_commit;
  logic          spd_done;
  logic [6:0]    spd_duty;
  logic [IW-1:0] spd_interval;
  logic [1:0]    dir_lvl;
  logic [31:0]   elapsed_us, ks_new, elapsed_ms;
  logic [6:0]    dn;
  logic          done;

  vftp_speed u_speed (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (spd_start),
    .mag       (q_cmd.mag),
    .min_speed (cfg.min_speed),
    .max_speed (cfg.max_speed),
    .freq_min  (cfg.freq_min),
    .freq_max  (cfg.freq_max),
    .ack       (spd_commit),
    .done      (spd_done),
    .duty      (spd_duty),
    .interval  (spd_interval)
  );

  assign out_free   = !out_valid_r || !out_stall;
  assign do_simple  = (bst_r == B_IDLE) && q_valid && (q_cmd.op != vftp_pkg::MODE_SPEED) &&
                      out_free;
  assign spd_start  = (bst_r == B_IDLE) && q_valid && (q_cmd.op == vftp_pkg::MODE_SPEED);
  assign spd_commit = (bst_r == B_SPD) && spd_done && out_free;
  assign q_pop      = do_simple || spd_start;
  assign out_valid  = out_valid_r;
  assign out_beat   = out_beat_r;

  // bit 0 is output a, bit 1 output b
  assign dir_lvl    = (rev_r || !cfg.two_outputs) ? 2'b01 : 2'b10;
  assign elapsed_us = q_cmd.now_us - last_us_r;
  assign ks_new     = on_r ? q_cmd.now_ms : ks_r;
  assign elapsed_ms = q_cmd.now_ms - ks_new;

  always_comb begin
    bst_nxt       = bst_r;
    step_nxt      = step_r;
    duty_now_nxt  = duty_now_r;
    duty_pend_nxt = duty_pend_r;
    int_now_nxt   = int_now_r;
    int_pend_nxt  = int_pend_r;
    last_us_nxt   = last_us_r;
    rev_nxt       = rev_r;
    on_nxt        = on_r;
    lvl_nxt       = lvl_r;
    ks_nxt        = ks_r;
    spd_neg_nxt   = spd_neg_r;
    spd_pos_nxt   = spd_pos_r;
    dn            = duty_now_r;
    done          = 1'b0;

    if (do_simple) begin
      case (q_cmd.op)
        vftp_pkg::MODE_TICK: begin
          if (elapsed_us >= 32'(int_now_r)) begin
            last_us_nxt = q_cmd.now_us;
            if (step_r == '0 && duty_pend_r != '0) begin
              lvl_nxt     = lvl_r | dir_lvl;
              dn          = duty_pend_r;
              int_now_nxt = int_pend_r;
            end
            duty_now_nxt = dn;
            if (CW'(step_r) == CW'(dn)) lvl_nxt = 2'b00;
            step_nxt = (step_r == SW'(DUTY_STEPS)) ? '0 : step_r + 1'b1;
          end
        end
        vftp_pkg::MODE_POWER: begin
          on_nxt = q_cmd.power_on;
          if (!q_cmd.power_on) lvl_nxt = 2'b00;
          else                 step_nxt = '0;
        end
        vftp_pkg::MODE_KICK: begin
          if (on_r) begin
            on_nxt  = 1'b0;
            lvl_nxt = dir_lvl;
            ks_nxt  = q_cmd.now_ms;
          end
          if (elapsed_ms > q_cmd.kdur) begin
            on_nxt  = 1'b1;
            lvl_nxt = 2'b00;
            done    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (spd_start) begin
      spd_neg_nxt = q_cmd.neg;
      spd_pos_nxt = q_cmd.pos;
      bst_nxt     = B_SPD;
    end

    if (spd_commit) begin
      if (spd_neg_r) rev_nxt = 1'b1;
      if (spd_pos_r) rev_nxt = 1'b0;
      duty_pend_nxt = spd_duty;
      int_pend_nxt  = spd_interval;
      bst_nxt       = B_IDLE;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (do_simple || spd_commit) begin
      out_valid_nxt          = 1'b1;
      out_beat_nxt.pin_a     = lvl_nxt[0];
      out_beat_nxt.pin_b     = lvl_nxt[1];
      out_beat_nxt.powered   = on_nxt;
      out_beat_nxt.kick_done = done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r       <= B_IDLE;
      step_r      <= '0;
      duty_now_r  <= '0;
      duty_pend_r <= '0;
      int_now_r   <= '0;
      int_pend_r  <= '0;
      last_us_r   <= '0;
      rev_r       <= 1'b0;
      on_r        <= 1'b1;
      lvl_r       <= 2'b00;
      ks_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bst_r       <= bst_nxt;
      step_r      <= step_nxt;
      duty_now_r  <= duty_now_nxt;
      duty_pend_r <= duty_pend_nxt;
      int_now_r   <= int_now_nxt;
      int_pend_r  <= int_pend_nxt;
      last_us_r   <= last_us_nxt;
      rev_r       <= rev_nxt;
      on_r        <= on_nxt;
      lvl_r       <= lvl_nxt;
      ks_r        <= ks_nxt;
      out_valid_r <= out_valid_nxt;
    end
    spd_neg_r  <= spd_neg_nxt;
    spd_pos_r  <= spd_pos_nxt;
    out_beat_r <= out_beat_nxt;
  end

endmodule

// File: rtl/variable_frequency_track_pwm.sv
// tick, power and kick-start beats pass the front stage register, the command queue and the result register
// throughput: one such beat per cycle while out_stall allows it and no set-speed beat is in work; a set-speed beat
//   holds the back end until the bit-serial divide of the 14-bit interval and the mapping multiplies are done
// a command queue of QUEUE_DEPTH entries (2 by default) lets input beats be taken while the back end is busy
// reset: synchronous, active low; config returns to defaults, outputs low, powered on
// top level: config registers, front stage, command queue and back end
module variable_frequency_track_pwm #(
  parameter int unsigned DUTY_STEPS  = vftp_pkg::DUTY_STEPS_DEF,
  parameter int unsigned QUEUE_DEPTH = vftp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  vftp_pkg::in_beat_t            in_beat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output vftp_pkg::out_beat_t           out_beat,
  input  logic                          cfg_we,
  input  logic [vftp_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [vftp_pkg::CFG_DW-1:0]   cfg_wdata
);

  vftp_pkg::cfg_t cfg_r, cfg_nxt;
  logic           q_push, q_ready, q_valid, q_pop;
  vftp_pkg::cmd_t push_cmd, q_cmd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        vftp_pkg::CFG_FREQ_MIN:    cfg_nxt.freq_min    = cfg_wdata;
        vftp_pkg::CFG_FREQ_MAX:    cfg_nxt.freq_max    = cfg_wdata;
        vftp_pkg::CFG_MIN_SPEED:   cfg_nxt.min_speed   = cfg_wdata[6:0];
        vftp_pkg::CFG_MAX_SPEED:   cfg_nxt.max_speed   = cfg_wdata[6:0];
        vftp_pkg::CFG_TWO_OUTPUTS: cfg_nxt.two_outputs = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.freq_min    <= vftp_pkg::FREQ_MIN_RST;
      cfg_r.freq_max    <= vftp_pkg::FREQ_MAX_RST;
      cfg_r.min_speed   <= vftp_pkg::MIN_SPEED_RST;
      cfg_r.max_speed   <= vftp_pkg::MAX_SPEED_RST;
      cfg_r.two_outputs <= vftp_pkg::TWO_OUTPUTS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vftp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready)
  );

  vftp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .pop        (q_pop)
  );

  vftp_back #(
    .DUTY_STEPS (DUTY_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  // while the queue has no room, a beat held by the front stage stalls the input
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_ready |-> in_stall)
    else $error("front stage pushed into a full queue");

  // a finished kick leaves the track powered with both outputs low
  a_kick_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.kick_done |-> out_beat.powered && !out_beat.pin_a && !out_beat.pin_b)
    else $error("kick done with outputs driven or power off");

  // reset empties the result register and frees the input side
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset left a beat pending");

endmodule
